>>> rtl/core/irpr_pkg.sv
// ----------------------------------------------------------------------------
// irpr_pkg
// Shared types, opcode and operand-kind codes and helper functions of the
// IR peephole rewriter.
// ----------------------------------------------------------------------------
package irpr_pkg;

  localparam int VALUE_BITS = 64;
  localparam int DIV_BITS   = 64;
  localparam int NSTG       = DIV_BITS + 2;

  localparam logic [4:0] OP_ASSIGN = 5'd0;
  localparam logic [4:0] OP_ADD    = 5'd1;
  localparam logic [4:0] OP_SUB    = 5'd2;
  localparam logic [4:0] OP_NEG    = 5'd3;
  localparam logic [4:0] OP_MUL    = 5'd4;
  localparam logic [4:0] OP_DIV    = 5'd5;
  localparam logic [4:0] OP_MOD    = 5'd6;
  localparam logic [4:0] OP_AND    = 5'd7;
  localparam logic [4:0] OP_OR     = 5'd8;
  localparam logic [4:0] OP_XOR    = 5'd9;
  localparam logic [4:0] OP_NOT    = 5'd10;
  localparam logic [4:0] OP_SHL    = 5'd11;
  localparam logic [4:0] OP_SHR    = 5'd12;
  localparam logic [4:0] OP_EQ     = 5'd13;
  localparam logic [4:0] OP_NE     = 5'd14;
  localparam logic [4:0] OP_LT     = 5'd15;
  localparam logic [4:0] OP_LE     = 5'd16;
  localparam logic [4:0] OP_GT     = 5'd17;
  localparam logic [4:0] OP_GE     = 5'd18;
  localparam logic [4:0] OP_CAST   = 5'd19;

  localparam logic [1:0] K_NONE  = 2'd0;
  localparam logic [1:0] K_TEMP  = 2'd1;
  localparam logic [1:0] K_CONST = 2'd2;
  localparam logic [1:0] K_OTHER = 2'd3;

  localparam logic [63:0] MASK_BYTE = 64'h0000_0000_0000_00FF;
  localparam logic [63:0] MASK_HALF = 64'h0000_0000_0000_FFFF;

  // Item passed from the classifier to the execution pipeline.
  typedef struct packed {
    logic        is_fold;
    logic [4:0]  op;
    logic [5:0]  sh;
    logic [63:0] a;
    logic [63:0] b;
    logic [4:0]  o_cmd;
    logic [1:0]  o_lk;
    logic [63:0] o_lv;
    logic [1:0]  o_rk;
    logic [63:0] o_rv;
    logic        o_chg;
  } fq_t;

  typedef struct packed {
    logic        vld;
    fq_t         it;
    logic [63:0] res;
    logic [63:0] dvd;
    logic [63:0] dvs;
    logic [63:0] rem;
    logic [63:0] quo;
    logic [63:0] acc;
    logic        neg_q;
    logic        neg_m;
  } bs_t;

  // Two's complement wrap to VALUE_BITS, sign-extended back to 64 bits.
  function automatic logic [63:0] wrap_v(input logic [63:0] v);
    logic [63:0] m;
    m = {64{1'b1}} >> (64 - VALUE_BITS);
    return (v & m) | (v[VALUE_BITS-1] ? ~m : 64'd0);
  endfunction

  function automatic logic [63:0] mag(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  // Bit index of a one-hot word.
  function automatic logic [5:0] onehot_idx(input logic [63:0] v);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = n | 6'(i);
    end
    return n;
  endfunction

endpackage

>>> rtl/core/irpr_front.sv
// ----------------------------------------------------------------------------
// irpr_front
// Classifies an incoming instruction: binary folds are handed on with their
// operands, every other rewrite is resolved here in full.
// ----------------------------------------------------------------------------
module irpr_front import irpr_pkg::*; (
  input  logic [4:0]  cmd,
  input  logic [1:0]  lk,
  input  logic [63:0] lv,
  input  logic [1:0]  rk,
  input  logic [63:0] rv,
  input  logic [3:0]  bytes,
  input  logic        uns,
  output fq_t         item
);

  logic        lc, rc, is_bin, fold_bin, un_fold, pow2;
  logic [63:0] cval, un_v, rv_m1;
  logic [5:0]  n_log;
  logic        keep, zero;

  assign lc    = (lk == K_CONST);
  assign rc    = (rk == K_CONST);
  assign cval  = lc ? lv : rv;
  assign rv_m1 = rv - 64'd1;
  assign pow2  = (rv != 64'd0) && !rv[63] && ((rv & rv_m1) == 64'd0);
  assign n_log = onehot_idx(rv);

  always_comb begin
    case (cmd) inside
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR, OP_XOR,
      OP_SHL, OP_SHR, OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE: is_bin = 1'b1;
      default: is_bin = 1'b0;
    endcase
  end

  assign fold_bin = is_bin && lc && rc;

  always_comb begin
    un_fold = 1'b0;
    un_v    = lv;
    case (cmd)
      OP_NEG: begin
        un_fold = lc;
        un_v    = 64'd0 - lv;
      end
      OP_NOT: begin
        un_fold = lc;
        un_v    = ~lv;
      end
      OP_CAST: begin
        un_fold = lc && (bytes != 4'd0);
        case (bytes)
          4'd1:    un_v = {{56{lv[7]}}, lv[7:0]};
          4'd2:    un_v = {{48{lv[15]}}, lv[15:0]};
          4'd4:    un_v = {{32{lv[31]}}, lv[31:0]};
          default: un_v = lv;
        endcase
      end
      default: ;
    endcase
  end

  // Algebraic identities with a single constant operand.
  always_comb begin
    keep = 1'b0;
    zero = 1'b0;
    if (lc || rc) begin
      case (cmd) inside
        OP_ADD, OP_OR, OP_XOR: keep = (cval == 64'd0);
        OP_SUB, OP_SHL, OP_SHR: keep = rc && (cval == 64'd0);
        OP_MUL: begin
          zero = (cval == 64'd0);
          keep = (cval == 64'd1);
        end
        OP_DIV: keep = rc && (cval == 64'd1);
        OP_AND: begin
          zero = (cval == 64'd0);
          keep = (cval == {64{1'b1}}) || (cval == MASK_HALF) || (cval == MASK_BYTE);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    item         = '0;
    item.op      = cmd;
    item.sh      = rv[5:0];
    item.a       = wrap_v(lv);
    item.b       = wrap_v(rv);
    item.o_cmd   = cmd;
    item.o_lk    = lk;
    item.o_lv    = lv;
    item.o_rk    = rk;
    item.o_rv    = rv;
    item.o_chg   = 1'b0;
    if (fold_bin) begin
      item.is_fold = 1'b1;
      item.o_chg   = 1'b1;
    end else if (un_fold) begin
      item.o_cmd = OP_ASSIGN;
      item.o_lk  = K_CONST;
      item.o_lv  = wrap_v(un_v);
      item.o_chg = 1'b1;
    end else if (keep || zero) begin
      item.o_cmd = OP_ASSIGN;
      if (zero) begin
        item.o_lk = K_CONST;
        item.o_lv = 64'd0;
      end else if (lc) begin
        item.o_lk = rk;
        item.o_lv = rv;
      end
      item.o_rk  = K_NONE;
      item.o_rv  = 64'd0;
      item.o_chg = 1'b1;
    end else if (rc && pow2) begin
      if (cmd == OP_MUL) begin
        item.o_cmd = OP_SHL;
        item.o_rv  = {58'd0, n_log};
        item.o_chg = 1'b1;
      end else if (cmd == OP_DIV && uns) begin
        item.o_cmd = OP_SHR;
        item.o_rv  = {58'd0, n_log};
        item.o_chg = 1'b1;
      end else if (cmd == OP_MOD && uns) begin
        // The mask may itself be an identity of AND on the second round.
        item.o_chg = 1'b1;
        if (rv_m1 == 64'd0) begin
          item.o_cmd = OP_ASSIGN;
          item.o_lk  = K_CONST;
          item.o_lv  = 64'd0;
          item.o_rk  = K_NONE;
          item.o_rv  = 64'd0;
        end else if (rv_m1 == MASK_BYTE || rv_m1 == MASK_HALF) begin
          item.o_cmd = OP_ASSIGN;
          item.o_rk  = K_NONE;
          item.o_rv  = 64'd0;
        end else begin
          item.o_cmd = OP_AND;
          item.o_rv  = rv_m1;
        end
      end
    end
  end

endmodule

>>> rtl/core/irpr_queue.sv
// ----------------------------------------------------------------------------
// irpr_queue
// Four-entry queue between the classifier and the execution pipeline.
// ----------------------------------------------------------------------------
module irpr_queue import irpr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  fq_t  wdata,
  input  logic pop,
  output fq_t  rdata,
  output logic full,
  output logic empty
);

  fq_t        mem_r [4];
  logic [1:0] wptr_r, rptr_r;
  logic [2:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 3'd4);
  assign empty = (cnt_r == 3'd0);
  assign rdata = mem_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 3'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 2'd0;
      rptr_r <= 2'd0;
      cnt_r  <= 3'd0;
    end else begin
      if (push) wptr_r <= wptr_r + 2'd1;
      if (pop) rptr_r <= rptr_r + 2'd1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= wdata;
  end

endmodule

>>> rtl/core/irpr_back.sv
// ----------------------------------------------------------------------------
// irpr_back
// Execution pipeline: simple ALU, split multiplier and a restoring divider
// with one quotient bit per stage, then the output register.
// ----------------------------------------------------------------------------
module irpr_back import irpr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  fq_t         q_data,
  input  logic        q_empty,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  o_cmd,
  output logic [1:0]  o_lk,
  output logic [63:0] o_lv,
  output logic [1:0]  o_rk,
  output logic [63:0] o_rv,
  output logic        o_chg
);

  bs_t         st_r   [NSTG];
  bs_t         alu_nxt;
  logic        adv;
  logic        out_vld_r;
  logic [4:0]  cmd_r;
  logic [1:0]  lk_r, rk_r;
  logic [63:0] lv_r, rv_r;
  logic        chg_r;
  logic [63:0] fin_val;
  bs_t         fin;

  // The whole pipeline moves together whenever the output register frees up.
  assign adv   = !out_vld_r || !out_stall;
  assign q_pop = adv && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r[0].vld <= 1'b0;
    end else if (adv) begin
      st_r[0].vld <= !q_empty;
      st_r[0].it  <= q_data;
    end
  end

  always_comb begin
    alu_nxt       = st_r[0];
    alu_nxt.dvd   = mag(st_r[0].it.a);
    alu_nxt.dvs   = mag(st_r[0].it.b);
    alu_nxt.rem   = 64'd0;
    alu_nxt.quo   = 64'd0;
    alu_nxt.acc   = 64'd0;
    alu_nxt.neg_q = st_r[0].it.a[63] ^ st_r[0].it.b[63];
    alu_nxt.neg_m = st_r[0].it.a[63];
    case (st_r[0].it.op)
      OP_ADD:  alu_nxt.res = st_r[0].it.a + st_r[0].it.b;
      OP_SUB:  alu_nxt.res = st_r[0].it.a - st_r[0].it.b;
      OP_AND:  alu_nxt.res = st_r[0].it.a & st_r[0].it.b;
      OP_OR:   alu_nxt.res = st_r[0].it.a | st_r[0].it.b;
      OP_XOR:  alu_nxt.res = st_r[0].it.a ^ st_r[0].it.b;
      OP_SHL:  alu_nxt.res = st_r[0].it.a << st_r[0].it.sh;
      OP_SHR:  alu_nxt.res = 64'($signed(st_r[0].it.a) >>> st_r[0].it.sh);
      OP_EQ:   alu_nxt.res = {63'd0, st_r[0].it.a == st_r[0].it.b};
      OP_NE:   alu_nxt.res = {63'd0, st_r[0].it.a != st_r[0].it.b};
      OP_LT:   alu_nxt.res = {63'd0, $signed(st_r[0].it.a) < $signed(st_r[0].it.b)};
      OP_LE:   alu_nxt.res = {63'd0, $signed(st_r[0].it.a) <= $signed(st_r[0].it.b)};
      OP_GT:   alu_nxt.res = {63'd0, $signed(st_r[0].it.a) > $signed(st_r[0].it.b)};
      OP_GE:   alu_nxt.res = {63'd0, $signed(st_r[0].it.a) >= $signed(st_r[0].it.b)};
      default: alu_nxt.res = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r[1].vld <= 1'b0;
    else if (adv) st_r[1] <= alu_nxt;
  end

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
    bs_t         step_nxt;
    logic [63:0] trial;
    logic [63:0] prod;
    logic [31:0] ma, mb;

    assign trial = {st_r[k+1].rem[62:0], st_r[k+1].dvd[63]};

    // The low 64 bits of the product are built from three 32x32 partials.
    always_comb begin
      ma = st_r[k+1].it.a[31:0];
      mb = st_r[k+1].it.b[31:0];
      if (k == 1) mb = st_r[k+1].it.b[63:32];
      if (k == 2) ma = st_r[k+1].it.a[63:32];
      prod = ma * mb;
    end

    always_comb begin
      step_nxt     = st_r[k+1];
      step_nxt.dvd = {st_r[k+1].dvd[62:0], 1'b0};
      if (trial >= st_r[k+1].dvs) begin
        step_nxt.rem = trial - st_r[k+1].dvs;
        step_nxt.quo = {st_r[k+1].quo[62:0], 1'b1};
      end else begin
        step_nxt.rem = trial;
        step_nxt.quo = {st_r[k+1].quo[62:0], 1'b0};
      end
      if (k == 0) step_nxt.acc = prod;
      else if (k == 1 || k == 2) step_nxt.acc = st_r[k+1].acc + {prod[31:0], 32'd0};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) st_r[k+2].vld <= 1'b0;
      else if (adv) st_r[k+2] <= step_nxt;
    end
  end

  assign fin = st_r[NSTG-1];

  always_comb begin
    case (fin.it.op)
      OP_MUL:  fin_val = fin.acc;
      OP_DIV:  fin_val = (fin.it.b == 64'd0) ? 64'd0 :
                         (fin.neg_q ? (64'd0 - fin.quo) : fin.quo);
      OP_MOD:  fin_val = (fin.it.b == 64'd0) ? 64'd0 :
                         (fin.neg_m ? (64'd0 - fin.rem) : fin.rem);
      default: fin_val = fin.res;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= fin.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (fin.it.is_fold) begin
        cmd_r <= OP_ASSIGN;
        lk_r  <= K_CONST;
        lv_r  <= wrap_v(fin_val);
        rk_r  <= K_NONE;
        rv_r  <= 64'd0;
        chg_r <= 1'b1;
      end else begin
        cmd_r <= fin.it.o_cmd;
        lk_r  <= fin.it.o_lk;
        lv_r  <= fin.it.o_lv;
        rk_r  <= fin.it.o_rk;
        rv_r  <= fin.it.o_rv;
        chg_r <= fin.it.o_chg;
      end
    end
  end

  assign out_valid = out_vld_r;
  assign o_cmd     = cmd_r;
  assign o_lk      = lk_r;
  assign o_lv      = lv_r;
  assign o_rk      = rk_r;
  assign o_rv      = rv_r;
  assign o_chg     = chg_r;

endmodule

>>> rtl/core/ir_peephole_rewriter_top.sv
// ----------------------------------------------------------------------------
// ir_peephole_rewriter_top
// Rewrites one IR instruction per item to its peephole fixed point.
// ----------------------------------------------------------------------------
// An instruction item enters on the in_ channel and its rewritten form leaves
// on the out_ channel, one result for every item, in order. Both channels
// move an item on a cycle where valid is high and stall is low.
// The classifier resolves identities and strength reduction at the input and
// writes the item into a four-entry queue. The execution pipeline then
// evaluates constant folds: a simple ALU stage, a multiplier split into three
// 32x32 partial products, and a restoring divider with one quotient bit per
// stage. After the queue come an input register, the ALU stage, the 64
// divider stages and the output register. Throughput is one item per cycle
// while out_stall is low. While out_stall holds back a shown result the whole
// pipeline freezes, the queue fills and in_stall rises once it is full; the
// result on out_ holds steady.
// Reset empties the queue and pipeline; no result is shown until new items
// have been accepted.
// ----------------------------------------------------------------------------
module ir_peephole_rewriter_top import irpr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [4:0]         in_cmd,
  input  logic [1:0]         in_left_kind,
  input  logic signed [63:0] in_left_value,
  input  logic [1:0]         in_right_kind,
  input  logic signed [63:0] in_right_value,
  input  logic [3:0]         in_result_bytes,
  input  logic               in_left_is_unsigned,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         out_cmd,
  output logic [1:0]         out_left_kind,
  output logic signed [63:0] out_left_value,
  output logic [1:0]         out_right_kind,
  output logic signed [63:0] out_right_value,
  output logic               out_was_changed
);

  fq_t         f_item, q_data;
  logic        q_full, q_empty, q_pop, push;
  logic [63:0] lv_o, rv_o;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  irpr_front u_front (
    .cmd   (in_cmd),
    .lk    (in_left_kind),
    .lv    (in_left_value),
    .rk    (in_right_kind),
    .rv    (in_right_value),
    .bytes (in_result_bytes),
    .uns   (in_left_is_unsigned),
    .item  (f_item)
  );

  irpr_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (f_item),
    .pop   (q_pop),
    .rdata (q_data),
    .full  (q_full),
    .empty (q_empty)
  );

  irpr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (q_data),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .o_cmd     (out_cmd),
    .o_lk      (out_left_kind),
    .o_lv      (lv_o),
    .o_rk      (out_right_kind),
    .o_rv      (rv_o),
    .o_chg     (out_was_changed)
  );

  assign out_left_value  = $signed(lv_o);
  assign out_right_value = $signed(rv_o);

endmodule

>>> rtl/core/irpr_checker.sv
// ----------------------------------------------------------------------------
// irpr_checker
// Port-level checks of the IR peephole rewriter, bound to its top level.
// ----------------------------------------------------------------------------
module irpr_checker import irpr_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [4:0]         out_cmd,
  input logic [1:0]         out_left_kind,
  input logic signed [63:0] out_left_value,
  input logic [1:0]         out_right_kind,
  input logic signed [63:0] out_right_value,
  input logic               out_was_changed
);

  // A result held back by the receiver stays put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cmd) &&
      $stable(out_left_kind) && $stable(out_left_value) &&
      $stable(out_right_kind) && $stable(out_right_value) && $stable(out_was_changed))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown straight after reset");

  // A rewrite that is not an assign can only come from strength reduction.
  a_reduce: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_was_changed && out_cmd != OP_ASSIGN |->
      (out_cmd == OP_SHL || out_cmd == OP_SHR || out_cmd == OP_AND) &&
      out_right_kind == K_CONST)
    else $error("changed item with unexpected opcode");

  a_shift: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_was_changed && (out_cmd == OP_SHL || out_cmd == OP_SHR) |->
      out_right_value[63:6] == 58'd0)
    else $error("reduced shift count out of range");

endmodule

bind ir_peephole_rewriter_top irpr_checker u_chk (.*);

>>> tb/ir_peephole_rewriter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_peephole_rewriter_checker
// Watches both channels of the peephole rewriter, predicts the rewritten
// instruction for every accepted item and compares it with each result.
// ----------------------------------------------------------------------------
module ir_peephole_rewriter_checker import irpr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [4:0]  in_cmd,
  input  logic [1:0]  in_left_kind,
  input  logic [63:0] in_left_value,
  input  logic [1:0]  in_right_kind,
  input  logic [63:0] in_right_value,
  input  logic [3:0]  in_result_bytes,
  input  logic        in_left_is_unsigned,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [4:0]  out_cmd,
  input  logic [1:0]  out_left_kind,
  input  logic [63:0] out_left_value,
  input  logic [1:0]  out_right_kind,
  input  logic [63:0] out_right_value,
  input  logic        out_was_changed,
  output int          errors,
  output int          pending
);

  typedef struct {
    logic [4:0]  op;
    logic [1:0]  lk;
    logic [63:0] lv;
    logic [1:0]  rk;
    logic [63:0] rv;
    logic        chg;
  } insn_t;

  insn_t rewritten_q[$];

  function automatic logic [63:0] const_fold_value(logic [4:0] op, logic [63:0] l,
                                                   logic [63:0] r);
    logic [63:0] q, m;
    case (op)
      OP_ADD: return l + r;
      OP_SUB: return l - r;
      OP_MUL: return l * r;
      OP_DIV, OP_MOD: begin
        if (r == 64'd0) return 64'd0;
        q = mag(l) / mag(r);
        m = mag(l) % mag(r);
        if (op == OP_DIV) return (l[63] ^ r[63]) ? 64'd0 - q : q;
        return l[63] ? 64'd0 - m : m;
      end
      OP_AND: return l & r;
      OP_OR:  return l | r;
      OP_XOR: return l ^ r;
      OP_SHL: return l << r[5:0];
      OP_SHR: return $signed(l) >>> r[5:0];
      OP_EQ:  return {63'd0, l == r};
      OP_NE:  return {63'd0, l != r};
      OP_LT:  return {63'd0, $signed(l) < $signed(r)};
      OP_LE:  return {63'd0, $signed(l) <= $signed(r)};
      OP_GT:  return {63'd0, $signed(l) > $signed(r)};
      OP_GE:  return {63'd0, $signed(l) >= $signed(r)};
      default: return 64'd0;
    endcase
  endfunction

  // Runs fold, simplify and reduce rounds until one changes nothing, at most four.
  function automatic insn_t rewrite_insn(insn_t x, logic [3:0] bytes, logic uns);
    logic        f, s, r, lc, rc;
    logic [63:0] v, c;
    int          act, n;
    x.chg = 1'b0;
    for (int round = 0; round < 4; round++) begin
      f = 1'b1;
      if (x.op >= OP_ADD && x.op <= OP_GE && x.op != OP_NEG && x.op != OP_NOT &&
          x.lk == K_CONST && x.rk == K_CONST) begin
        v = const_fold_value(x.op, x.lv, x.rv);
        x.rk = K_NONE;
        x.rv = 64'd0;
      end else if (x.op == OP_NEG && x.lk == K_CONST) begin
        v = 64'd0 - x.lv;
      end else if (x.op == OP_NOT && x.lk == K_CONST) begin
        v = ~x.lv;
      end else if (x.op == OP_CAST && x.lk == K_CONST && bytes != 4'd0) begin
        v = x.lv;
        if (bytes == 4'd1) v = {{56{v[7]}}, v[7:0]};
        else if (bytes == 4'd2) v = {{48{v[15]}}, v[15:0]};
        else if (bytes == 4'd4) v = {{32{v[31]}}, v[31:0]};
      end else begin
        f = 1'b0;
      end
      if (f) begin
        x.op = OP_ASSIGN;
        x.lk = K_CONST;
        x.lv = v;
      end
      // Algebraic identities: act 1 keeps the variable operand, 2 gives zero.
      lc = (x.lk == K_CONST);
      rc = (x.rk == K_CONST);
      act = 0;
      c = lc ? x.lv : x.rv;
      if (lc || rc) begin
        case (x.op)
          OP_ADD, OP_OR, OP_XOR: if (c == 64'd0) act = 1;
          OP_SUB, OP_SHL, OP_SHR: if (rc && c == 64'd0) act = 1;
          OP_MUL: if (c == 64'd0) act = 2; else if (c == 64'd1) act = 1;
          OP_DIV: if (rc && c == 64'd1) act = 1;
          OP_AND: begin
            if (c == 64'd0) act = 2;
            else if (c == '1 || c == MASK_HALF || c == MASK_BYTE) act = 1;
          end
          default: act = 0;
        endcase
      end
      s = (act != 0);
      if (act == 2) begin
        x.lk = K_CONST;
        x.lv = 64'd0;
      end else if (act == 1 && lc) begin
        x.lk = x.rk;
        x.lv = x.rv;
      end
      if (s) begin
        x.op = OP_ASSIGN;
        x.rk = K_NONE;
        x.rv = 64'd0;
      end
      // Strength reduction on a positive power of two on the right.
      r = 1'b0;
      if (x.rk == K_CONST && x.rv != 64'd0 && !x.rv[63] && (x.rv & (x.rv - 1)) == 64'd0) begin
        n = 0;
        for (int i = 0; i < 64; i++) if (x.rv[i]) n = i;
        if (x.op == OP_MUL) begin
          x.op = OP_SHL; x.rv = 64'(n); r = 1'b1;
        end else if (x.op == OP_DIV && uns) begin
          x.op = OP_SHR; x.rv = 64'(n); r = 1'b1;
        end else if (x.op == OP_MOD && uns) begin
          x.op = OP_AND; x.rv = x.rv - 64'd1; r = 1'b1;
        end
      end
      if (!(f || s || r)) break;
      x.chg = 1'b1;
    end
    return x;
  endfunction

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    insn_t e, a;
    int    nerr;
    nerr = 0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (rewritten_q.size() == 0) begin
          $error("result with no item outstanding");
          nerr++;
        end else begin
          e = rewritten_q.pop_front();
          if (out_cmd !== e.op) begin
            $error("out_cmd: expected %0d, got %0d", e.op, out_cmd);
            nerr++;
          end
          if (out_left_kind !== e.lk) begin
            $error("out_left_kind: expected %0d, got %0d", e.lk, out_left_kind);
            nerr++;
          end
          if (out_left_value !== e.lv) begin
            $error("out_left_value: expected %h, got %h", e.lv, out_left_value);
            nerr++;
          end
          if (out_right_kind !== e.rk) begin
            $error("out_right_kind: expected %0d, got %0d", e.rk, out_right_kind);
            nerr++;
          end
          if (out_right_value !== e.rv) begin
            $error("out_right_value: expected %h, got %h", e.rv, out_right_value);
            nerr++;
          end
          if (out_was_changed !== e.chg) begin
            $error("out_was_changed: expected %0d, got %0d", e.chg, out_was_changed);
            nerr++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        a.op = in_cmd;
        a.lk = in_left_kind;
        a.lv = in_left_value;
        a.rk = in_right_kind;
        a.rv = in_right_value;
        a.chg = 1'b0;
        rewritten_q.push_back(rewrite_insn(a, in_result_bytes, in_left_is_unsigned));
      end
    end
    errors  <= errors + nerr;
    pending <= rewritten_q.size();
  end

endmodule

>>> tb/ir_peephole_rewriter_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_peephole_rewriter_top_test
// Drives directed and random IR instructions into the peephole rewriter
// under varying back-pressure; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module ir_peephole_rewriter_top_test import irpr_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [63:0] MIN_VAL = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_VAL = 64'h7FFF_FFFF_FFFF_FFFF;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [4:0]  in_cmd;
  logic [1:0]  in_left_kind;
  logic [63:0] in_left_value;
  logic [1:0]  in_right_kind;
  logic [63:0] in_right_value;
  logic [3:0]  in_result_bytes;
  logic        in_left_is_unsigned;
  logic        out_valid;
  logic        out_stall;
  logic [4:0]  out_cmd;
  logic [1:0]  out_left_kind;
  logic [63:0] out_left_value;
  logic [1:0]  out_right_kind;
  logic [63:0] out_right_value;
  logic        out_was_changed;
  int          errors;
  int          pending;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          quiet_cycles;

  ir_peephole_rewriter_top uut (.*);

  ir_peephole_rewriter_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(logic [4:0] op, logic [1:0] lk, logic [63:0] lv,
                           logic [1:0] rk, logic [63:0] rv, logic [3:0] bytes,
                           logic uns);
    in_valid            <= 1'b1;
    in_cmd              <= op;
    in_left_kind        <= lk;
    in_left_value       <= lv;
    in_right_kind       <= rk;
    in_right_value      <= rv;
    in_result_bytes     <= bytes;
    in_left_is_unsigned <= uns;
    do @(posedge clk); while (in_stall);
    // Each cycle after an item is idle with the sender's idle share.
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Mostly boundary values and powers of two, so that the identities and
  // reductions fire often; the rest is fully random.
  function automatic logic [63:0] pick_value();
    case ($urandom_range(11))
      0: return 64'd0;
      1: return 64'd1;
      2: return '1;
      3: return MIN_VAL;
      4: return MAX_VAL;
      5: return MASK_BYTE;
      6: return MASK_HALF;
      7: return 64'd1 << $urandom_range(63);
      8: return 64'($urandom_range(70));
      9: return -64'($urandom_range(70));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [1:0] pick_kind();
    if ($urandom_range(1)) return K_CONST;
    return 2'($urandom_range(3));
  endfunction

  initial begin
    logic [4:0] op;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = OP_ASSIGN;
    in_left_kind = K_NONE;
    in_left_value = 64'd0;
    in_right_kind = K_NONE;
    in_right_value = 64'd0;
    in_result_bytes = 4'd0;
    in_left_is_unsigned = 1'b0;
    out_stall = 1'b0;
    quiet_cycles = 0;
    send_idle_pct = 27;
    recv_idle_pct = 86;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: folds at the extremes, the division corner cases, casts,
    // identities and reductions, and opcodes that are never rewritten.
    send_item(OP_ADD, K_CONST, MAX_VAL, K_CONST, 64'd1, 4'd8, 1'b0);
    send_item(OP_SUB, K_CONST, MIN_VAL, K_CONST, 64'd1, 4'd8, 1'b0);
    send_item(OP_MUL, K_CONST, MAX_VAL, K_CONST, MAX_VAL, 4'd8, 1'b0);
    send_item(OP_DIV, K_CONST, 64'd77, K_CONST, 64'd0, 4'd8, 1'b0);
    send_item(OP_MOD, K_CONST, 64'd77, K_CONST, 64'd0, 4'd8, 1'b0);
    send_item(OP_DIV, K_CONST, MIN_VAL, K_CONST, '1, 4'd8, 1'b0);
    send_item(OP_MOD, K_CONST, MIN_VAL, K_CONST, '1, 4'd8, 1'b0);
    send_item(OP_MOD, K_CONST, -64'sd7, K_CONST, 64'd3, 4'd8, 1'b0);
    send_item(OP_SHL, K_CONST, 64'd5, K_CONST, 64'd67, 4'd8, 1'b0);
    send_item(OP_SHR, K_CONST, MIN_VAL, K_CONST, 64'd63, 4'd8, 1'b0);
    send_item(OP_LT, K_CONST, MIN_VAL, K_CONST, MAX_VAL, 4'd1, 1'b0);
    send_item(OP_GE, K_CONST, MIN_VAL, K_CONST, MAX_VAL, 4'd1, 1'b0);
    send_item(OP_NEG, K_CONST, MIN_VAL, K_TEMP, 64'd9, 4'd8, 1'b0);
    send_item(OP_NOT, K_CONST, 64'd0, K_OTHER, 64'd3, 4'd8, 1'b0);
    send_item(OP_CAST, K_CONST, 64'h1234_5678_9ABC_DEF0, K_NONE, 64'd0, 4'd1, 1'b0);
    send_item(OP_CAST, K_CONST, 64'h1234_5678_9ABC_8EF0, K_NONE, 64'd0, 4'd2, 1'b0);
    send_item(OP_CAST, K_CONST, 64'h1234_5678_9ABC_DEF0, K_NONE, 64'd0, 4'd4, 1'b0);
    send_item(OP_CAST, K_CONST, 64'h1234_5678_9ABC_DEF0, K_NONE, 64'd0, 4'd0, 1'b0);
    send_item(OP_MOD, K_TEMP, 64'd4, K_CONST, 64'd1, 4'd8, 1'b1);
    send_item(OP_MUL, K_TEMP, 64'd4, K_CONST, 64'd8, 4'd8, 1'b0);
    send_item(OP_DIV, K_TEMP, 64'd4, K_CONST, 64'd16, 4'd8, 1'b1);
    send_item(OP_DIV, K_TEMP, 64'd4, K_CONST, 64'd16, 4'd8, 1'b0);
    send_item(OP_AND, K_CONST, MASK_BYTE, K_TEMP, 64'd6, 4'd8, 1'b0);
    send_item(OP_ADD, K_CONST, 64'd0, K_OTHER, 64'd2, 4'd8, 1'b0);
    send_item(5'd25, K_CONST, 64'd1, K_CONST, 64'd2, 4'd15, 1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      // Hold off until the pipeline has drained before changing the pressure.
      in_valid <= 1'b0;
      @(posedge clk);
      while (pending != 0) @(posedge clk);
      send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 86 : 0;
      recv_idle_pct = (phase == 0) ? 86 : (phase == 1) ? 27 : 0;
      for (int k = 0; k < 617; k++) begin
        op = ($urandom_range(15) == 0) ? 5'($urandom_range(20, 31))
                                       : 5'($urandom_range(0, 19));
        send_item(op, pick_kind(), pick_value(), pick_kind(), pick_value(),
                  4'($urandom_range(15)), 1'($urandom_range(1)));
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
